/* rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SWALLOW = 3'd5
  } phase_t;

  // event codes on the result channel
  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_PING    = 2'd1;
  localparam logic [1:0] EV_CLOSE   = 2'd2;
  localparam logic [1:0] EV_EMPTY   = 2'd3;

  // opcodes and length escapes
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // header byte counts
  localparam logic [3:0] HDR_EXT16 = 4'd2;
  localparam logic [3:0] HDR_EXT64 = 4'd8;
  localparam logic [3:0] HDR_KEY   = 4'd4;

  // one result item
  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       fin_bit;
    logic       last_of_frame;
  } result_t;

endpackage

/* rtl/wsd_if.sv */
// ----------------------------------------------------------------------------
// wsd interfaces
// Valid/ready channels for stream bytes and deframer results.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       fin_bit;
  logic       last_of_frame;

  modport source (output valid, output event_kind, output payload_byte,
                  output frame_opcode, output fin_bit, output last_of_frame,
                  input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input frame_opcode, input fin_bit, input last_of_frame,
                  output ready);
endinterface

/* rtl/wsd_in_stage.sv */
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register that holds one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // room when empty or when the held byte leaves this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // byte capture on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

/* rtl/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header state machine, payload unmasking and event generation.
// ----------------------------------------------------------------------------
module wsd_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       byte_data,
  output logic             res_valid,
  output wsd_pkg::result_t res
);

  wsd_pkg::phase_t        phase_r, phase_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             kidx_r, kidx_nxt;
  logic                   masked_r, masked_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   fin_r, fin_nxt;

  logic                   hdr_done;
  logic                   to_key;
  logic [3:0]             cnt_dec;
  logic [LENGTH_BITS-1:0] left_dec;
  logic [LENGTH_BITS-1:0] left_shift;
  logic [7:0]             key_byte;
  logic                   left_last;

  // shared helpers
  always_comb begin
    cnt_dec  = (cnt_r != 4'd0) ? cnt_r - 4'd1 : 4'd0;
    left_dec = (left_r != '0) ? left_r - LENGTH_BITS'(1) : '0;
    // at most one byte left means this one ends the frame
    left_last = (left_r[LENGTH_BITS-1:1] == '0);
    if (left_r[LENGTH_BITS-1 -: 8] != 8'd0) begin
      left_shift = '1;
    end else begin
      left_shift = {left_r[LENGTH_BITS-9:0], byte_data};
    end
    key_byte = 8'd0;
    if (masked_r) begin
      case (kidx_r)
        2'd0:    key_byte = key_r[31:24];
        2'd1:    key_byte = key_r[23:16];
        2'd2:    key_byte = key_r[15:8];
        default: key_byte = key_r[7:0];
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    left_nxt   = left_r;
    key_nxt    = key_r;
    kidx_nxt   = kidx_r;
    masked_nxt = masked_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;
    hdr_done   = 1'b0;
    to_key     = 1'b0;

    unique case (phase_r)
      wsd_pkg::PH_SECOND: begin
        masked_nxt = byte_data[7];
        if (byte_data[6:0] == wsd_pkg::LEN_EXT16 || byte_data[6:0] == wsd_pkg::LEN_EXT64) begin
          cnt_nxt   = (byte_data[6:0] == wsd_pkg::LEN_EXT16) ?
                      wsd_pkg::HDR_EXT16 : wsd_pkg::HDR_EXT64;
          left_nxt  = '0;
          phase_nxt = wsd_pkg::PH_EXTLEN;
        end else begin
          left_nxt = {{(LENGTH_BITS-7){1'b0}}, byte_data[6:0]};
          to_key   = byte_data[7];
          hdr_done = !byte_data[7];
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        left_nxt = left_shift;
        cnt_nxt  = cnt_dec;
        if (cnt_dec == 4'd0) begin
          to_key   = masked_r;
          hdr_done = !masked_r;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_nxt = {key_r[23:0], byte_data};
        cnt_nxt = cnt_dec;
        if (cnt_dec == 4'd0) begin
          hdr_done = 1'b1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        kidx_nxt = kidx_r + 2'd1;
        left_nxt = left_dec;
        if (left_last) begin
          phase_nxt = wsd_pkg::PH_FIRST;
        end
      end
      wsd_pkg::PH_SWALLOW: begin
        left_nxt = left_dec;
        if (left_last) begin
          phase_nxt = wsd_pkg::PH_FIRST;
        end
      end
      default: begin
        fin_nxt    = byte_data[7];
        opcode_nxt = byte_data[3:0];
        phase_nxt  = wsd_pkg::PH_SECOND;
      end
    endcase

    // mask key follows the length
    if (to_key) begin
      cnt_nxt   = wsd_pkg::HDR_KEY;
      phase_nxt = wsd_pkg::PH_KEY;
    end

    // header complete: control frame, empty frame or payload
    if (hdr_done) begin
      kidx_nxt = 2'd0;
      if (opcode_r == wsd_pkg::OP_PING || opcode_r == wsd_pkg::OP_CLOSE) begin
        phase_nxt = (left_nxt != '0) ? wsd_pkg::PH_SWALLOW : wsd_pkg::PH_FIRST;
      end else if (left_nxt == '0) begin
        phase_nxt = wsd_pkg::PH_FIRST;
      end else begin
        phase_nxt = wsd_pkg::PH_PAYLOAD;
      end
    end
  end

  // result for the parsed byte
  always_comb begin
    res_valid         = 1'b0;
    res.event_kind    = wsd_pkg::EV_PAYLOAD;
    res.payload_byte  = 8'd0;
    res.frame_opcode  = opcode_r;
    res.fin_bit       = fin_r;
    res.last_of_frame = 1'b1;
    if (phase_r == wsd_pkg::PH_PAYLOAD) begin
      res_valid         = 1'b1;
      res.payload_byte  = byte_data ^ key_byte;
      res.last_of_frame = left_last;
    end else if (hdr_done) begin
      if (opcode_r == wsd_pkg::OP_PING || opcode_r == wsd_pkg::OP_CLOSE) begin
        res_valid      = 1'b1;
        res.event_kind = (opcode_r == wsd_pkg::OP_PING) ? wsd_pkg::EV_PING : wsd_pkg::EV_CLOSE;
      end else if (left_nxt == '0) begin
        res_valid      = 1'b1;
        res.event_kind = wsd_pkg::EV_EMPTY;
      end
    end
  end

  // state registers, updated on each parsed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_FIRST;
      cnt_r    <= 4'd0;
      left_r   <= '0;
      key_r    <= 32'd0;
      kidx_r   <= 2'd0;
      masked_r <= 1'b0;
      opcode_r <= 4'd0;
      fin_r    <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      left_r   <= left_nxt;
      key_r    <= key_nxt;
      kidx_r   <= kidx_nxt;
      masked_r <= masked_nxt;
      opcode_r <= opcode_nxt;
      fin_r    <= fin_nxt;
    end
  end

`ifndef SYNTH
  // a payload byte always yields a result
  a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsd_pkg::PH_PAYLOAD) |-> res_valid)
    else $error("payload byte without result");

  // control and empty events always close the frame
  a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.event_kind != wsd_pkg::EV_PAYLOAD) |-> res.last_of_frame)
    else $error("event without last flag");

  // a first header byte is followed by the second
  a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_r == wsd_pkg::PH_FIRST) |=> (phase_r == wsd_pkg::PH_SECOND))
    else $error("first header byte did not advance");

  // header counter is live while collecting length or key
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsd_pkg::PH_EXTLEN || phase_r == wsd_pkg::PH_KEY) |-> (cnt_r != 4'd0))
    else $error("header count zero inside header");
`endif

endmodule

/* rtl/wsd_out_stage.sv */
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register that holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             res_valid,
  input  wsd_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output wsd_pkg::result_t out_res
);

  logic             valid_r;
  logic             valid_nxt;
  wsd_pkg::result_t res_r;

  // empty, or the held result is transferred this cycle
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (free && load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* rtl/websocket_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side websocket frame parser, one byte per cycle unless out_ch stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries the received frame stream, one byte per transfer. out_ch
//   carries results: payload bytes unmasked with the frame key, one ping or
//   close event at the end of a ping or close header, or an empty-frame event
//   for any other frame of length zero. last_of_frame marks the final result.
//   Header bytes and ping or close payload give no result.
//   Path: a transferred byte is held in the input register and parsed when
//   the result register has room; its result then loads into the result
//   register, which drives out_ch.valid.
//   Throughput: one byte per cycle unless out_ch stalls; the frame state
//   update in between is a single pass with one LENGTH_BITS wide decrement.
//   Reset: rst_n low returns the parser to the first header byte and clears
//   the valid flags of both registers; no item is held after reset.
//   Stall: while out_ch.ready is low the held result stays put; the input
//   register still takes one byte, after which in_ch.ready drops until the
//   result is transferred.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  wsd_in_if.sink     in_ch,
  wsd_out_if.source  out_ch
);

  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             fire;
  logic             free;
  logic             res_valid;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_res;

  // parse the held byte when the result register has room
  assign fire = byte_valid && free;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_byte    (in_ch.in_byte),
    .in_ready   (in_ch.ready),
    .take       (fire),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .byte_data (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_valid (res_valid),
    .res       (res),
    .free      (free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // result fields onto the channel
  assign out_ch.event_kind    = out_res.event_kind;
  assign out_ch.payload_byte  = out_res.payload_byte;
  assign out_ch.frame_opcode  = out_res.frame_opcode;
  assign out_ch.fin_bit       = out_res.fin_bit;
  assign out_ch.last_of_frame = out_res.last_of_frame;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream test of the websocket frame deframer: directed frames first,
// then random frames, with a shadow parser predicting each event in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int LEN_BITS   = 64;
  localparam int RAND_ITEMS = 1200;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN      = 8;
  localparam int QUIET_TAIL = 100;
  localparam int MODE_SPAN  = 160;

  // how a frame header carries its length
  typedef enum int {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wsd_in_if  in_if ();
  wsd_out_if out_if ();

  websocket_frame_deframer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #1 clk = ~clk;

  // stream waiting to go in, events waiting to come out
  logic [7:0]       stream_bytes [$];
  wsd_pkg::result_t expected_events [$];
  int               total_bytes;
  int               in_accepted;
  int               in_presented;
  int               errors;

  // shadow parser state
  wsd_pkg::phase_t     fr_phase;
  logic [3:0]          fr_hdr_left;
  logic [LEN_BITS-1:0] fr_len_left;
  logic [31:0]         fr_key;
  logic [1:0]          fr_key_idx;
  logic                fr_masked;
  logic [3:0]          fr_opcode;
  logic                fr_fin;

  function automatic wsd_pkg::result_t make_event(input logic [1:0] kind,
                                                  input logic [7:0] data,
                                                  input logic last);
    wsd_pkg::result_t r;
    r.event_kind    = kind;
    r.payload_byte  = data;
    r.frame_opcode  = fr_opcode;
    r.fin_bit       = fr_fin;
    r.last_of_frame = last;
    return r;
  endfunction

  // end of header: control event, empty event, or go to payload
  task automatic header_done();
    logic [1:0] kind;
    fr_key_idx = 2'd0;
    if (fr_opcode == wsd_pkg::OP_PING || fr_opcode == wsd_pkg::OP_CLOSE) begin
      kind = (fr_opcode == wsd_pkg::OP_PING) ? wsd_pkg::EV_PING : wsd_pkg::EV_CLOSE;
      expected_events.push_back(make_event(kind, 8'h00, 1'b1));
      fr_phase = (fr_len_left != '0) ? wsd_pkg::PH_SWALLOW : wsd_pkg::PH_FIRST;
    end else if (fr_len_left == '0) begin
      expected_events.push_back(make_event(wsd_pkg::EV_EMPTY, 8'h00, 1'b1));
      fr_phase = wsd_pkg::PH_FIRST;
    end else begin
      fr_phase = wsd_pkg::PH_PAYLOAD;
    end
  endtask

  // length complete: key follows when masked
  task automatic length_known();
    if (fr_masked) begin
      fr_hdr_left = wsd_pkg::HDR_KEY;
      fr_phase    = wsd_pkg::PH_KEY;
    end else begin
      header_done();
    end
  endtask

  // advance the shadow parser by one stream byte
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] key_byte;
    int         shift;
    case (fr_phase)
      wsd_pkg::PH_SECOND: begin
        fr_masked = b[7];
        if (b[6:0] == wsd_pkg::LEN_EXT16 || b[6:0] == wsd_pkg::LEN_EXT64) begin
          fr_hdr_left = (b[6:0] == wsd_pkg::LEN_EXT16) ?
                        wsd_pkg::HDR_EXT16 : wsd_pkg::HDR_EXT64;
          fr_len_left = '0;
          fr_phase    = wsd_pkg::PH_EXTLEN;
        end else begin
          fr_len_left      = '0;
          fr_len_left[6:0] = b[6:0];
          length_known();
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        // saturate when the length would overflow
        if (fr_len_left[LEN_BITS-1 -: 8] != 8'd0) fr_len_left = '1;
        else fr_len_left = {fr_len_left[LEN_BITS-9:0], b};
        if (fr_hdr_left != 4'd0) fr_hdr_left = fr_hdr_left - 4'd1;
        if (fr_hdr_left == 4'd0) length_known();
      end
      wsd_pkg::PH_KEY: begin
        fr_key = {fr_key[23:0], b};
        if (fr_hdr_left != 4'd0) fr_hdr_left = fr_hdr_left - 4'd1;
        if (fr_hdr_left == 4'd0) header_done();
      end
      wsd_pkg::PH_PAYLOAD: begin
        shift    = 8 * (3 - int'(fr_key_idx));
        key_byte = fr_masked ? 8'(fr_key >> shift) : 8'h00;
        fr_key_idx = fr_key_idx + 2'd1;
        if (fr_len_left != '0) fr_len_left = fr_len_left - 1'b1;
        if (fr_len_left == '0) fr_phase = wsd_pkg::PH_FIRST;
        expected_events.push_back(make_event(wsd_pkg::EV_PAYLOAD, b ^ key_byte,
                                             fr_len_left == '0));
      end
      wsd_pkg::PH_SWALLOW: begin
        if (fr_len_left != '0) fr_len_left = fr_len_left - 1'b1;
        if (fr_len_left == '0) fr_phase = wsd_pkg::PH_FIRST;
      end
      default: begin
        fr_fin    = b[7];
        fr_opcode = b[3:0];
        fr_phase  = wsd_pkg::PH_SECOND;
      end
    endcase
  endtask

  // queue one frame; body is the number of payload bytes actually sent
  task automatic queue_frame(input logic [7:0] head, input logic masked,
                             input logic [63:0] len, input int unsigned body,
                             input len_enc_t enc);
    logic [31:0] key;
    key = $urandom;
    stream_bytes.push_back(head);
    case (enc)
      ENC_SHORT: stream_bytes.push_back({masked, len[6:0]});
      ENC_EXT16: begin
        stream_bytes.push_back({masked, wsd_pkg::LEN_EXT16});
        stream_bytes.push_back(len[15:8]);
        stream_bytes.push_back(len[7:0]);
      end
      default: begin
        stream_bytes.push_back({masked, wsd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) stream_bytes.push_back(len[8*i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) stream_bytes.push_back(key[8*i +: 8]);
    for (int unsigned i = 0; i < body; i++) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic bit burst_starts(input int mode);
    case (mode)
      0:       return 1'b0;
      1:       return $urandom_range(0, 15) == 0;
      default: return $urandom_range(0, 3) == 0;
    endcase
  endfunction

  // stimulus, reset and end of run
  initial begin
    int          rand_items;
    int          before_cnt;
    int          pick;
    int          roll;
    int unsigned len;
    logic [3:0]  op;
    logic [2:0]  rsv;
    logic        fin;
    logic        masked;
    logic [7:0]  head;
    len_enc_t    enc;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    out_if.ready  = 1'b0;
    fr_phase      = wsd_pkg::PH_FIRST;
    fr_hdr_left   = '0;
    fr_len_left   = '0;
    fr_key        = '0;
    fr_key_idx    = '0;
    fr_masked     = 1'b0;
    fr_opcode     = '0;
    fr_fin        = 1'b0;
    in_accepted   = 0;
    in_presented  = 0;
    errors        = 0;

    // directed frames
    stream_bytes = '{
      8'h81, 8'h02, 8'h00, 8'hFF,                      // unmasked text, bytes 00 and ff
      8'h89, 8'h00,                                    // ping, no payload
      8'h08, 8'h81, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h5A, // close, fin clear, payload swallowed
      8'h02, 8'h00,                                    // empty binary, fin clear
      8'hFF, 8'h7E, 8'h00, 8'h02, 8'hC3, 8'h3C,        // rsv bits set, reserved opcode, short 16-bit length
      8'h8A, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04         // masked pong of length zero
    };

    // random frames, mostly well formed
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      fin  = $urandom_range(0, 3) != 0;
      rsv  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
      if (pick < 10) op = wsd_pkg::OP_PING;
      else if (pick < 20) op = wsd_pkg::OP_CLOSE;
      else if (pick < 75) op = 4'($urandom_range(0, 2));
      else begin
        do op = 4'($urandom_range(0, 15));
        while (op == wsd_pkg::OP_PING || op == wsd_pkg::OP_CLOSE);
      end
      head = {fin, rsv, op};
      // noise header: any first byte at all
      if (pick >= 95) head = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 85) len = $urandom_range(0, 12);
      else if (roll < 97) len = $urandom_range(13, 125);
      else len = $urandom_range(126, 400);
      roll = $urandom_range(0, 9);
      if (len > 125) enc = (roll < 5) ? ENC_EXT16 : ENC_EXT64;
      else if (roll < 7) enc = ENC_SHORT;
      else if (roll < 9) enc = ENC_EXT16;
      else enc = ENC_EXT64;
      masked = $urandom_range(0, 9) < 6;
      before_cnt = stream_bytes.size();
      queue_frame(head, masked, 64'(len), len, enc);
      rand_items += stream_bytes.size() - before_cnt;
    end

    // length with its top bit set: the frame stays open to the end
    queue_frame(8'h82, 1'b1, 64'h8000_0000_0000_0005, 12, ENC_EXT64);
    total_bytes = stream_bytes.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (in_accepted != total_bytes || expected_events.size() != 0);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("** websocket_frame_deframer_unit: PASSED **");
    end else begin
      $display("** websocket_frame_deframer_unit: FAILED **");
    end
    $finish;
  end

  // byte driver
  int in_gap;
  int in_mode;
  int in_cycle;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap   = 0;
      in_mode  = 0;
      in_cycle = 0;
    end else begin
      if (in_cycle % MODE_SPAN == 0) in_mode = $urandom_range(0, 2);
      in_cycle++;
      if (in_accepted == in_presented) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (stream_bytes.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (in_accepted + QUIET_TAIL < total_bytes && burst_starts(in_mode)) begin
          in_gap = $urandom_range(1, 19) - 1;
          in_if.valid <= 1'b0;
        end else begin
          in_if.in_byte <= stream_bytes.pop_front();
          in_if.valid   <= 1'b1;
          in_presented++;
        end
      end
    end
  end

  // result ready driver
  int out_gap;
  int out_mode;
  int out_cycle;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_gap   = 0;
      out_mode  = 0;
      out_cycle = 0;
    end else begin
      if (out_cycle % MODE_SPAN == 0) out_mode = $urandom_range(0, 2);
      out_cycle++;
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else if (in_accepted + QUIET_TAIL < total_bytes && burst_starts(out_mode)) begin
        out_gap = $urandom_range(1, 19) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic int field_mismatch(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  // monitor: predict on byte transfers, check on result transfers
  int idle_cycles = 0;
  always @(posedge clk) begin
    wsd_pkg::result_t want;
    int               bad;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.in_byte);
        in_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result, kind %0d byte %0d", $time,
                   out_if.event_kind, out_if.payload_byte);
          errors++;
        end else begin
          want = expected_events.pop_front();
          bad  = field_mismatch("event_kind", want.event_kind, out_if.event_kind)
               + field_mismatch("payload_byte", want.payload_byte, out_if.payload_byte)
               + field_mismatch("frame_opcode", want.frame_opcode, out_if.frame_opcode)
               + field_mismatch("fin_bit", want.fin_bit, out_if.fin_bit)
               + field_mismatch("last_of_frame", want.last_of_frame, out_if.last_of_frame);
          if (bad != 0) errors++;
        end
      end
      // watchdog on cycles without any transfer
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("** websocket_frame_deframer_unit: FAILED **");
        $finish;
      end
    end
  end

endmodule
